// File: rtl/core/pmcc_pkg.sv
// ----------------------------------------------------------------------------
// pmcc_pkg
// Shared types and constants for the palette and mask colour converter.
// ----------------------------------------------------------------------------
package pmcc_pkg;

    localparam int unsigned PALETTE_DEPTH = 256;
    localparam int unsigned IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int unsigned CNT_W         = $clog2(PALETTE_DEPTH + 1);
    localparam int unsigned ENTRY_W       = 24;

    // floor(x / 9) for x < 2296 as (x * 7282) >> 16
    localparam int unsigned SUM_W         = 12;
    localparam int unsigned DIV9_MUL      = 7282;
    localparam int unsigned DIV9_MUL_W    = 13;
    localparam int unsigned DIV9_SHIFT    = 16;
    localparam int unsigned PROD_W        = SUM_W + DIV9_MUL_W;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_DECODE = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        CFG_MODE   = 3'd0,
        CFG_RPOS   = 3'd1,
        CFG_RWIDTH = 3'd2,
        CFG_GPOS   = 3'd3,
        CFG_GWIDTH = 3'd4,
        CFG_BPOS   = 3'd5,
        CFG_BWIDTH = 3'd6,
        CFG_LIMIT  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic       palette_mode;
        logic [4:0] red_position;
        logic [3:0] red_width;
        logic [4:0] green_position;
        logic [3:0] green_width;
        logic [4:0] blue_position;
        logic [3:0] blue_width;
        logic [7:0] match_limit;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic             vld;
        logic [IDX_W-1:0] idx;
    } dist_ctl_t;

endpackage

// File: rtl/core/pmcc_ram.sv
// ----------------------------------------------------------------------------
// pmcc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pmcc_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/pmcc_direct.sv
// ----------------------------------------------------------------------------
// pmcc_direct
// Direct-colour field packing and unpacking from the mask registers.
// ----------------------------------------------------------------------------
module pmcc_direct import pmcc_pkg::*; (
    input  cfg_t        cfg,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [31:0] pixel,
    output logic [31:0] enc_pixel,
    output logic [7:0]  dec_red,
    output logic [7:0]  dec_green,
    output logic [7:0]  dec_blue
);

    function automatic logic [3:0] eff_width(input logic [3:0] w);
        return (w > 4'd8) ? 4'd8 : w;
    endfunction

    function automatic logic [31:0] pack_field(input logic [7:0] c, input logic [4:0] pos,
                                               input logic [3:0] w);
        logic [3:0] ew;
        logic [7:0] f;
        ew = eff_width(w);
        f  = c >> (4'd8 - ew);
        return {24'd0, f} << pos;
    endfunction

    function automatic logic [7:0] unpack_field(input logic [31:0] px, input logic [4:0] pos,
                                                input logic [3:0] w);
        logic [3:0]  ew;
        logic [31:0] sh;
        logic [8:0]  m9;
        logic [7:0]  f;
        ew = eff_width(w);
        sh = px >> pos;
        m9 = (9'd1 << ew) - 9'd1;
        f  = sh[7:0] & m9[7:0];
        return f << (4'd8 - ew);
    endfunction

    always_comb
    begin
        enc_pixel = pack_field(red, cfg.red_position, cfg.red_width)
                  | pack_field(green, cfg.green_position, cfg.green_width)
                  | pack_field(blue, cfg.blue_position, cfg.blue_width);
        dec_red   = unpack_field(pixel, cfg.red_position, cfg.red_width);
        dec_green = unpack_field(pixel, cfg.green_position, cfg.green_width);
        dec_blue  = unpack_field(pixel, cfg.blue_position, cfg.blue_width);
    end

endmodule

// File: rtl/core/pmcc_dist.sv
// ----------------------------------------------------------------------------
// pmcc_dist
// Shared distance unit: one palette entry per cycle, weighted L1 sum, then
// divide by nine and keep the first strictly smaller distance.
// ----------------------------------------------------------------------------
module pmcc_dist import pmcc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  dist_ctl_t          ctl,
    input  logic [ENTRY_W-1:0] entry,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic [7:0]         limit,
    output logic [IDX_W-1:0]   hit_idx,
    output logic               busy
);

    logic [7:0]       dr;
    logic [7:0]       dg;
    logic [7:0]       db;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_reg;
    logic [IDX_W-1:0] sum_idx_reg;
    logic             sum_vld_reg;
    logic [PROD_W-1:0] prod;
    logic [7:0]       quot;
    logic [7:0]       best_reg;
    logic [IDX_W-1:0] hit_reg;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb
    begin
        dr       = abs_diff(red, entry[23:16]);
        dg       = abs_diff(green, entry[15:8]);
        db       = abs_diff(blue, entry[7:0]);
        sum_next = SUM_W'({dr, 1'b0}) + SUM_W'(dg) + SUM_W'({dg, 1'b0})
                 + SUM_W'({db, 2'b00});
        prod     = PROD_W'(sum_reg) * PROD_W'(DIV9_MUL);
        quot     = prod[DIV9_SHIFT +: 8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_vld_reg <= 1'b0;
        end
        else
        begin
            sum_vld_reg <= ctl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg     <= sum_next;
        sum_idx_reg <= ctl.idx;
        if (ctl.start)
        begin
            best_reg <= limit;
            hit_reg  <= '0;
        end
        else if (sum_vld_reg && (quot < best_reg))
        begin
            best_reg <= quot;
            hit_reg  <= sum_idx_reg;
        end
    end

    assign hit_idx = hit_reg;
    assign busy    = sum_vld_reg;

endmodule

// File: rtl/core/palette_and_mask_color_converter_top.sv
// ----------------------------------------------------------------------------
// palette_and_mask_color_converter_top
// RGB to pixel and pixel to RGB conversion, direct-colour masks or a
// 256-entry palette with nearest-colour search.
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid/req_stall  | req_type, entry_index, colour, pixel
//   rsp     | out       | rsp_valid/rsp_stall  | out_pixel, out_red/green/blue
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Palette write: written to the RAM when taken, no response beat.
// Direct-colour encode/decode: ST_DIRECT, then ST_EMIT to the response register.
// Palette decode: one RAM read (ST_LOOKUP, ST_LDATA, ST_EMIT). Palette encode:
// one palette entry per cycle through the single RAM read port, then ST_DRAIN.
// Reset clears the palette valid bits at once; no sweep is needed.
// req_stall is high while an item is in flight; a stalled response does not
// block the next request, but that item waits in ST_EMIT until the beat is taken.
// ----------------------------------------------------------------------------
module palette_and_mask_color_converter_top import pmcc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,
    input  logic [31:0] in_pixel,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [31:0] out_pixel,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DIRECT = 7'b0000010,
        ST_LOOKUP = 7'b0000100,
        ST_LDATA  = 7'b0001000,
        ST_SCAN   = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    cfg_t               cfg_reg;
    logic               req_accept;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               ent_vld_reg [PALETTE_DEPTH];
    logic               rd_vld_reg;
    logic               rd_pend_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [ENTRY_W-1:0] ent_data;
    logic [CNT_W-1:0]   scan_cnt_reg;
    logic [1:0]         type_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         blue_reg;
    logic [31:0]        pix_reg;
    logic               pix_in_range;
    logic [31:0]        res_pix_reg;
    logic [7:0]         res_red_reg;
    logic [7:0]         res_green_reg;
    logic [7:0]         res_blue_reg;
    logic               rsp_valid_reg;
    logic [31:0]        out_pixel_reg;
    logic [7:0]         out_red_reg;
    logic [7:0]         out_green_reg;
    logic [7:0]         out_blue_reg;
    logic               out_free;
    logic [31:0]        enc_pixel;
    logic [7:0]         dec_red;
    logic [7:0]         dec_green;
    logic [7:0]         dec_blue;
    dist_ctl_t          dist_ctl;
    logic [IDX_W-1:0]   hit_idx;
    logic               dist_busy;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign cfg_ready  = 1'b1;
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    assign ram_we    = req_accept && (req_type == REQ_WRITE)
                    && ({1'b0, entry_index} < 9'(PALETTE_DEPTH));
    assign ram_raddr = (state_reg == ST_SCAN) ? scan_cnt_reg[IDX_W-1:0]
                                              : pix_reg[IDX_W-1:0];
    assign ent_data     = rd_vld_reg ? ram_rdata : '0;
    assign pix_in_range = (pix_reg < 32'(PALETTE_DEPTH));

    pmcc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (entry_index[IDX_W-1:0]),
        .wdata ({in_red, in_green, in_blue}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pmcc_direct u_direct (
        .cfg       (cfg_reg),
        .red       (red_reg),
        .green     (green_reg),
        .blue      (blue_reg),
        .pixel     (pix_reg),
        .enc_pixel (enc_pixel),
        .dec_red   (dec_red),
        .dec_green (dec_green),
        .dec_blue  (dec_blue)
    );

    always_comb
    begin
        dist_ctl.start = req_accept;
        dist_ctl.vld   = rd_pend_reg;
        dist_ctl.idx   = rd_idx_reg;
    end

    pmcc_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (dist_ctl),
        .entry   (ent_data),
        .red     (red_reg),
        .green   (green_reg),
        .blue    (blue_reg),
        .limit   (cfg_reg.match_limit),
        .hit_idx (hit_idx),
        .busy    (dist_busy)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    case (req_type)
                        REQ_ENCODE: state_next = cfg_reg.palette_mode ? ST_SCAN : ST_DIRECT;
                        REQ_DECODE: state_next = cfg_reg.palette_mode ? ST_LOOKUP : ST_DIRECT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIRECT: state_next = ST_EMIT;
            ST_LOOKUP: state_next = ST_LDATA;
            ST_LDATA:  state_next = ST_EMIT;
            ST_SCAN:
            begin
                if (scan_cnt_reg == CNT_W'(PALETTE_DEPTH - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_pend_reg && !dist_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_vld_reg    <= 1'b0;
            scan_cnt_reg  <= '0;
            cfg_reg       <= '{palette_mode: 1'b0, red_position: 5'd11, red_width: 4'd5,
                               green_position: 5'd5, green_width: 4'd6,
                               blue_position: 5'd0, blue_width: 4'd5,
                               match_limit: 8'd100};
            for (int i = 0; i < PALETTE_DEPTH; i++)
            begin
                ent_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_SCAN);
            rd_vld_reg  <= ent_vld_reg[ram_raddr];
            if (ram_we)
            begin
                ent_vld_reg[entry_index[IDX_W-1:0]] <= 1'b1;
            end
            if (req_accept)
            begin
                scan_cnt_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if ((state_reg == ST_EMIT) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODE:   cfg_reg.palette_mode   <= cfg_data[0];
                    CFG_RPOS:   cfg_reg.red_position   <= cfg_data[4:0];
                    CFG_RWIDTH: cfg_reg.red_width      <= cfg_data[3:0];
                    CFG_GPOS:   cfg_reg.green_position <= cfg_data[4:0];
                    CFG_GWIDTH: cfg_reg.green_width    <= cfg_data[3:0];
                    CFG_BPOS:   cfg_reg.blue_position  <= cfg_data[4:0];
                    CFG_BWIDTH: cfg_reg.blue_width     <= cfg_data[3:0];
                    CFG_LIMIT:  cfg_reg.match_limit    <= cfg_data;
                    default:    cfg_reg                <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_cnt_reg[IDX_W-1:0];
        if (req_accept)
        begin
            type_reg  <= req_type;
            red_reg   <= in_red;
            green_reg <= in_green;
            blue_reg  <= in_blue;
            pix_reg   <= in_pixel;
        end
        case (state_reg)
            ST_DIRECT:
            begin
                if (type_reg == REQ_ENCODE)
                begin
                    res_pix_reg   <= enc_pixel;
                    res_red_reg   <= '0;
                    res_green_reg <= '0;
                    res_blue_reg  <= '0;
                end
                else
                begin
                    res_pix_reg   <= '0;
                    res_red_reg   <= dec_red;
                    res_green_reg <= dec_green;
                    res_blue_reg  <= dec_blue;
                end
            end
            ST_LDATA:
            begin
                res_pix_reg   <= '0;
                res_red_reg   <= pix_in_range ? ent_data[23:16] : 8'd0;
                res_green_reg <= pix_in_range ? ent_data[15:8] : 8'd0;
                res_blue_reg  <= pix_in_range ? ent_data[7:0] : 8'd0;
            end
            ST_DRAIN:
            begin
                res_pix_reg   <= 32'(hit_idx);
                res_red_reg   <= '0;
                res_green_reg <= '0;
                res_blue_reg  <= '0;
            end
            default:
            begin
                res_pix_reg <= res_pix_reg;
            end
        endcase
        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_pixel_reg <= res_pix_reg;
            out_red_reg   <= res_red_reg;
            out_green_reg <= res_green_reg;
            out_blue_reg  <= res_blue_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;

endmodule

// File: rtl/core/pmcc_checker.sv
// ----------------------------------------------------------------------------
// pmcc_checker
// Port-level checks for the palette and mask colour converter.
// ----------------------------------------------------------------------------
module pmcc_checker import pmcc_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic [1:0]  req_type,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [31:0] out_pixel,
    input logic [7:0]  out_red,
    input logic [7:0]  out_green,
    input logic [7:0]  out_blue
);

    // stalled response beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(out_pixel) && $stable(out_red)
                                   && $stable(out_green) && $stable(out_blue))
        else $error("stalled response beat changed");

    // a response carries either a pixel or a colour, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (out_pixel == 32'd0)
                   || ((out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0)))
        else $error("response carries both pixel and colour");

    // encode and decode keep the request side busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && ((req_type == REQ_ENCODE) || (req_type == REQ_DECODE))
        |=> req_stall)
        else $error("request taken while conversion in flight");

    // a palette write gives no response beat
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req_type == REQ_WRITE) && !rsp_valid |=> !rsp_valid)
        else $error("palette write produced a response");

endmodule

bind palette_and_mask_color_converter_top pmcc_checker u_pmcc_checker (.*);

// File: test/tb_palette_and_mask_color_converter_top.sv
// ----------------------------------------------------------------------------
// tb_palette_and_mask_color_converter_top
// Self-checking bench for the colour converter. A short table of directed
// beats covers the field extremes, both modes, palette hits and misses and
// out-of-range indexes. Random beats follow under changing register settings
// and three patterns of idle cycles. Every response is checked against an
// in-bench predictor of the palette and the mask fields, or a pinned value.
// ----------------------------------------------------------------------------
module tb_palette_and_mask_color_converter_top;
    import pmcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam int         SEGMENTS      = 6;
    localparam int         BEATS_PER_SEG = 74;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         TAIL_CYCLES   = 300;
    localparam int         CYCLE_LIMIT   = 2000000;

    typedef struct packed {
        logic [31:0] pixel;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } colour_rsp_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] pixel;
        logic        pinned;
        colour_rsp_t want;
    } colour_req_t;

    typedef struct packed {
        logic        is_setting;
        cfg_idx_t    reg_idx;
        logic [7:0]  reg_data;
        colour_req_t beat;
    } table_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    colour_req_t cur_item = '0;
    logic [1:0]  req_type;
    logic [7:0]  entry_index;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic [31:0] in_pixel;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [31:0] out_pixel;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_idx_t    cfg_index = CFG_MODE;
    logic [7:0]  cfg_data = '0;

    // predictor state
    cfg_t        colour_cfg;
    logic [23:0] palette_shadow [PALETTE_DEPTH];
    colour_rsp_t pending_conversions [$];

    int          req_idle_pct = 0;
    int          rsp_idle_pct = 0;
    bit          beats_since_settle = 1'b0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          encode_count = 0;
    int          search_count = 0;
    int          decode_count = 0;
    int          write_count = 0;
    int          setting_writes = 0;
    table_row_t  directed_rows [$];

    assign req_type    = cur_item.kind;
    assign entry_index = cur_item.index;
    assign in_red      = cur_item.red;
    assign in_green    = cur_item.green;
    assign in_blue     = cur_item.blue;
    assign in_pixel    = cur_item.pixel;

    palette_and_mask_color_converter_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .entry_index (entry_index),
        .in_red      (in_red),
        .in_green    (in_green),
        .in_blue     (in_blue),
        .in_pixel    (in_pixel),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .out_pixel   (out_pixel),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [3:0] field_width(logic [3:0] width);
        return (width > 4'd8) ? 4'd8 : width;
    endfunction

    function automatic logic [31:0] place_field(logic [7:0] chan, logic [4:0] pos,
                                                logic [3:0] width);
        logic [3:0]  w;
        logic [63:0] wide;
        w = field_width(width);
        if (w == 0)
            return '0;
        wide = 64'(chan >> (8 - w));
        wide = wide << pos;
        return wide[31:0];
    endfunction

    function automatic logic [7:0] extract_field(logic [31:0] pixel, logic [4:0] pos,
                                                 logic [3:0] width);
        logic [3:0]  w;
        logic [31:0] f;
        w = field_width(width);
        if (w == 0)
            return '0;
        f = (pixel >> pos) & ((32'd1 << w) - 32'd1);
        f = f << (8 - w);
        return f[7:0];
    endfunction

    function automatic int unsigned chan_gap(logic [7:0] a, logic [7:0] b);
        return (a > b) ? 32'(a - b) : 32'(b - a);
    endfunction

    // returns 1 when the beat yields a response
    function automatic bit convert_colour(input colour_req_t beat, output colour_rsp_t rsp);
        int unsigned best;
        int unsigned gap_sum;
        logic [23:0] entry;
        rsp = '0;
        case (beat.kind)
            REQ_WRITE:
            begin
                palette_shadow[beat.index] = {beat.red, beat.green, beat.blue};
                return 1'b0;
            end
            REQ_ENCODE:
            begin
                if (!colour_cfg.palette_mode)
                begin
                    rsp.pixel = place_field(beat.red, colour_cfg.red_position,
                                            colour_cfg.red_width)
                              | place_field(beat.green, colour_cfg.green_position,
                                            colour_cfg.green_width)
                              | place_field(beat.blue, colour_cfg.blue_position,
                                            colour_cfg.blue_width);
                end
                else
                begin
                    best = 32'(colour_cfg.match_limit);
                    for (int i = 0; i < PALETTE_DEPTH; i++)
                    begin
                        entry = palette_shadow[i];
                        gap_sum = (2 * chan_gap(beat.red, entry[23:16])
                                 + 3 * chan_gap(beat.green, entry[15:8])
                                 + 4 * chan_gap(beat.blue, entry[7:0])) / 9;
                        if (gap_sum < best)
                        begin
                            best = gap_sum;
                            rsp.pixel = i;
                        end
                    end
                end
            end
            REQ_DECODE:
            begin
                if (!colour_cfg.palette_mode)
                begin
                    rsp.red   = extract_field(beat.pixel, colour_cfg.red_position,
                                              colour_cfg.red_width);
                    rsp.green = extract_field(beat.pixel, colour_cfg.green_position,
                                              colour_cfg.green_width);
                    rsp.blue  = extract_field(beat.pixel, colour_cfg.blue_position,
                                              colour_cfg.blue_width);
                end
                else if (beat.pixel < PALETTE_DEPTH)
                begin
                    {rsp.red, rsp.green, rsp.blue} = palette_shadow[beat.pixel[7:0]];
                end
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_beats
        colour_rsp_t got;
        colour_rsp_t want;
        colour_rsp_t predicted;
        bit          produced;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                got = {out_pixel, out_red, out_green, out_blue};
                if (pending_conversions.size() == 0)
                    flag_mismatch("unexpected response", got.pixel, '0);
                else
                begin
                    want = pending_conversions.pop_front();
                    if (got.pixel !== want.pixel)
                        flag_mismatch("out_pixel", got.pixel, want.pixel);
                    if (got.red !== want.red)
                        flag_mismatch("out_red", got.red, want.red);
                    if (got.green !== want.green)
                        flag_mismatch("out_green", got.green, want.green);
                    if (got.blue !== want.blue)
                        flag_mismatch("out_blue", got.blue, want.blue);
                end
            end
            if (req_valid && !req_stall)
            begin
                case (cur_item.kind)
                    REQ_WRITE:  write_count++;
                    REQ_DECODE: decode_count++;
                    REQ_ENCODE:
                    begin
                        encode_count++;
                        if (colour_cfg.palette_mode)
                            search_count++;
                    end
                    default: ;
                endcase
                produced = convert_colour(cur_item, predicted);
                if (produced)
                    pending_conversions.push_back(cur_item.pinned ? cur_item.want : predicted);
            end
        end
    end

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < rsp_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_conversions.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_beat(colour_req_t beat);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        cur_item  <= beat;
        do
            @(posedge clk);
        while (req_stall);
        beats_since_settle = 1'b1;
    endtask

    // block idle: every response back and a palette write fully retired
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_conversions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        beats_since_settle = 1'b0;
    endtask

    task automatic write_setting(cfg_idx_t idx, logic [7:0] data);
        if (beats_since_settle)
            settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_MODE:   colour_cfg.palette_mode   = data[0];
            CFG_RPOS:   colour_cfg.red_position   = data[4:0];
            CFG_RWIDTH: colour_cfg.red_width      = data[3:0];
            CFG_GPOS:   colour_cfg.green_position = data[4:0];
            CFG_GWIDTH: colour_cfg.green_width    = data[3:0];
            CFG_BPOS:   colour_cfg.blue_position  = data[4:0];
            CFG_BWIDTH: colour_cfg.blue_width     = data[3:0];
            CFG_LIMIT:  colour_cfg.match_limit    = data;
            default: ;
        endcase
        setting_writes++;
    endtask

    function automatic logic [7:0] random_width_data();
        logic [3:0] w;
        w = ($urandom_range(99) < 80) ? 4'($urandom_range(8, 1)) : 4'($urandom_range(15));
        return {4'($urandom), w};
    endfunction

    task automatic pick_settings(bit palette_mode);
        int          pick;
        logic [7:0]  limit;
        pick = $urandom_range(99);
        limit = (pick < 15) ? 8'd0 : (pick < 30) ? 8'd255 : 8'($urandom);
        write_setting(CFG_MODE, {7'($urandom), palette_mode});
        write_setting(CFG_RPOS, 8'($urandom));
        write_setting(CFG_RWIDTH, random_width_data());
        write_setting(CFG_GPOS, 8'($urandom));
        write_setting(CFG_GWIDTH, random_width_data());
        write_setting(CFG_BPOS, 8'($urandom));
        write_setting(CFG_BWIDTH, random_width_data());
        write_setting(CFG_LIMIT, limit);
    endtask

    function automatic logic [7:0] nudge(logic [7:0] chan);
        int v;
        v = int'(chan) + $urandom_range(24) - 12;
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic colour_req_t random_beat();
        colour_req_t beat;
        int          pick;
        logic [23:0] entry;
        beat       = '0;
        beat.index = 8'($urandom);
        beat.red   = 8'($urandom);
        beat.green = 8'($urandom);
        beat.blue  = 8'($urandom);
        beat.pixel = $urandom;
        pick = $urandom_range(99);
        if (pick < 4)
            beat.kind = REQ_UNUSED;
        else if (pick < 30)
        begin
            beat.kind = REQ_WRITE;
            if ($urandom_range(1))
                beat.index = 8'($urandom_range(15));
        end
        else if (pick < 65)
        begin
            beat.kind = REQ_ENCODE;
            if ($urandom_range(1))
            begin
                entry = palette_shadow[8'($urandom_range(1) ? $urandom_range(15)
                                                            : $urandom_range(255))];
                beat.red   = nudge(entry[23:16]);
                beat.green = nudge(entry[15:8]);
                beat.blue  = nudge(entry[7:0]);
            end
            else if ($urandom_range(9) == 0)
                {beat.red, beat.green, beat.blue} = $urandom_range(1) ? '1 : '0;
        end
        else
        begin
            beat.kind = REQ_DECODE;
            if (colour_cfg.palette_mode && $urandom_range(99) < 85)
                beat.pixel = $urandom_range(255);
        end
        return beat;
    endfunction

    function automatic table_row_t req_row(logic [1:0] kind, logic [7:0] idx, logic [7:0] r,
                                           logic [7:0] g, logic [7:0] b, logic [31:0] px);
        table_row_t row;
        row = '0;
        row.beat.kind  = kind;
        row.beat.index = idx;
        row.beat.red   = r;
        row.beat.green = g;
        row.beat.blue  = b;
        row.beat.pixel = px;
        return row;
    endfunction

    function automatic table_row_t cfg_row(cfg_idx_t idx, logic [7:0] data);
        table_row_t row;
        row = '0;
        row.is_setting = 1'b1;
        row.reg_idx    = idx;
        row.reg_data   = data;
        return row;
    endfunction

    function automatic table_row_t pinned(table_row_t row, logic [31:0] px, logic [7:0] r,
                                          logic [7:0] g, logic [7:0] b);
        row.beat.pinned = 1'b1;
        row.beat.want   = {px, r, g, b};
        return row;
    endfunction

    initial
    begin
        int counted;
        colour_req_t beat;

        colour_cfg = '0;
        colour_cfg.red_position   = 5'd11;
        colour_cfg.red_width      = 4'd5;
        colour_cfg.green_position = 5'd5;
        colour_cfg.green_width    = 4'd6;
        colour_cfg.blue_position  = 5'd0;
        colour_cfg.blue_width     = 4'd5;
        colour_cfg.match_limit    = 8'd100;
        for (int i = 0; i < PALETTE_DEPTH; i++)
            palette_shadow[i] = '0;

        // default RGB565 layout straight after reset
        directed_rows.push_back(pinned(req_row(REQ_ENCODE, 0, 8'hFF, 8'hFF, 8'hFF, 0),
                                       32'h0000_FFFF, 0, 0, 0));
        directed_rows.push_back(pinned(req_row(REQ_ENCODE, 0, 0, 0, 0, 0), 0, 0, 0, 0));
        directed_rows.push_back(pinned(req_row(REQ_DECODE, 0, 0, 0, 0, 32'hFFFF_FFFF),
                                       0, 8'hF8, 8'hFC, 8'hF8));
        directed_rows.push_back(pinned(req_row(REQ_DECODE, 0, 0, 0, 0, 0), 0, 0, 0, 0));
        directed_rows.push_back(req_row(REQ_ENCODE, 0, 8'h80, 8'h40, 8'h20, 0));
        directed_rows.push_back(req_row(REQ_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
        directed_rows.push_back(req_row(REQ_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF, 0));
        directed_rows.push_back(req_row(REQ_WRITE, 8'd0, 8'h12, 8'h34, 8'h56, 0));
        // palette lookups, never-written entry and out-of-range index
        directed_rows.push_back(cfg_row(CFG_MODE, 8'd1));
        directed_rows.push_back(pinned(req_row(REQ_DECODE, 0, 0, 0, 0, 32'd255),
                                       0, 8'hFF, 8'hFF, 8'hFF));
        directed_rows.push_back(pinned(req_row(REQ_DECODE, 0, 0, 0, 0, 32'd0),
                                       0, 8'h12, 8'h34, 8'h56));
        directed_rows.push_back(pinned(req_row(REQ_DECODE, 0, 0, 0, 0, 32'd7), 0, 0, 0, 0));
        directed_rows.push_back(pinned(req_row(REQ_DECODE, 0, 0, 0, 0, 32'd256), 0, 0, 0, 0));
        directed_rows.push_back(pinned(req_row(REQ_DECODE, 0, 0, 0, 0, 32'hFFFF_FFFF),
                                       0, 0, 0, 0));
        directed_rows.push_back(req_row(REQ_ENCODE, 0, 8'hFF, 8'hFF, 8'hFF, 0));
        directed_rows.push_back(req_row(REQ_ENCODE, 0, 8'h80, 8'h80, 8'h80, 0));
        // zero limit: nothing can qualify
        directed_rows.push_back(cfg_row(CFG_LIMIT, 8'd0));
        directed_rows.push_back(pinned(req_row(REQ_ENCODE, 0, 8'h12, 8'h34, 8'h56, 0),
                                       0, 0, 0, 0));
        directed_rows.push_back(cfg_row(CFG_LIMIT, 8'd255));
        directed_rows.push_back(req_row(REQ_ENCODE, 0, 8'h28, 8'h28, 8'h28, 0));
        // empty field, oversized width, fields running off bit 31
        directed_rows.push_back(cfg_row(CFG_MODE, 8'd0));
        directed_rows.push_back(cfg_row(CFG_RWIDTH, 8'd0));
        directed_rows.push_back(cfg_row(CFG_RPOS, 8'd31));
        directed_rows.push_back(cfg_row(CFG_GWIDTH, 8'd15));
        directed_rows.push_back(cfg_row(CFG_GPOS, 8'd31));
        directed_rows.push_back(cfg_row(CFG_BWIDTH, 8'd8));
        directed_rows.push_back(cfg_row(CFG_BPOS, 8'd28));
        directed_rows.push_back(req_row(REQ_ENCODE, 0, 8'hFF, 8'hFF, 8'hFF, 0));
        directed_rows.push_back(req_row(REQ_ENCODE, 0, 8'hA5, 8'h5A, 8'hC3, 0));
        directed_rows.push_back(req_row(REQ_DECODE, 0, 0, 0, 0, 32'hFFFF_FFFF));
        directed_rows.push_back(req_row(REQ_DECODE, 0, 0, 0, 0, 32'h8000_0000));
        // overlapping red and blue fields
        directed_rows.push_back(cfg_row(CFG_RWIDTH, 8'd8));
        directed_rows.push_back(cfg_row(CFG_RPOS, 8'd0));
        directed_rows.push_back(cfg_row(CFG_BPOS, 8'd4));
        directed_rows.push_back(req_row(REQ_ENCODE, 0, 8'h3C, 8'h99, 8'hE1, 0));
        directed_rows.push_back(req_row(REQ_DECODE, 0, 0, 0, 0, 32'h0000_0ABC));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_setting)
                write_setting(directed_rows[r].reg_idx, directed_rows[r].reg_data);
            else
                send_beat(directed_rows[r].beat);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                pick_settings(1'(seg % 2));
                req_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 62 : 0;
                rsp_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 16 : 0;
                counted = 0;
                while (counted < BEATS_PER_SEG)
                begin
                    beat = random_beat();
                    send_beat(beat);
                    if (beat.kind != REQ_UNUSED)
                        counted++;
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d encodes (%0d palette searches), %0d decodes, %0d palette writes",
                 encode_count, search_count, decode_count, write_count);
        $display("%0d register writes over %0d cycles, %0d mismatches",
                 setting_writes, cycle_count, mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
